// ===== rtl/core/arc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arc_pkg: shared types and constants of the ARC replacement core
// Holds list codes, the sequencer state type and the front/back status group.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int PAGE_COUNT_DEF = 1024;
  localparam int PAGE_W         = 10;
  localparam int CAP_W          = 10;
  localparam int FAULT_W        = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 10'd256;

  // list that holds a page, as kept in the page table
  typedef enum logic [2:0] {
    TAG_NONE = 3'd0,
    TAG_T1   = 3'd1,
    TAG_T2   = 3'd2,
    TAG_B1   = 3'd3,
    TAG_B2   = 3'd4
  } tag_e;

  // list indexes for heads, tails and sizes
  localparam logic [1:0] LIST_T1 = 2'd0;
  localparam logic [1:0] LIST_T2 = 2'd1;
  localparam logic [1:0] LIST_B1 = 2'd2;
  localparam logic [1:0] LIST_B2 = 2'd3;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_DROP_SEL,
    ST_DROP_U0,
    ST_DROP_U1,
    ST_REPL_SEL,
    ST_REPL_U0,
    ST_REPL_U1,
    ST_REPL_P0,
    ST_REPL_P1,
    ST_REF_U0,
    ST_REF_U1,
    ST_REF_P0,
    ST_REF_P1
  } st_e;

  // back-end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/arc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arc_div: restoring divider for the adaptation step
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module arc_div import arc_pkg::*; #(
  parameter int W = 11,
  localparam int CW = $clog2(W + 1)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o
);

  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quot_q, quot_d;
  logic [W-1:0]  dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [W:0]    trial;

  // shift in one dividend bit and try a subtract
  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q[W-1:0], quot_q[W-1]};
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      cnt_d  = CW'(W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/core/arc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arc_front: command intake and item queue
// Accepts page references, folds them into the page table range and queues
// up to two items for the back end.
// ----------------------------------------------------------------------------
module arc_front import arc_pkg::*; #(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  localparam int PW = $clog2(PAGE_COUNT)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [PAGE_W-1:0] page_number_i,
  input  wire back_stat_t        stat_i,
  output logic                   item_valid_o,
  output logic [PW-1:0]          item_page_o
);

  logic [PW-1:0] page_red;
  logic [PW-1:0] slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          accept;

  // fold the page number into the table
  if (PAGE_COUNT >= (1 << PAGE_W)) begin : g_nofold
    assign page_red = PW'(page_number_i);
  end else begin : g_fold
    always_comb begin
      logic [PAGE_W:0] v;
      v = {1'b0, page_number_i};
      for (int k = 8; k >= 0; k--) begin
        if (32'(v) >= (32'(PAGE_COUNT) << k)) begin
          v = v - (PAGE_W + 1)'(32'(PAGE_COUNT) << k);
        end
      end
      page_red = PW'(v);
    end
  end

  assign busy         = (cnt_q == 2'd2) || stat_i.clearing;
  assign accept       = start && !busy;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_page_o  = slot_q[rd_ptr_q];

  // advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (stat_i.pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, accept} - {1'b0, stat_i.pop};
    end
  end

  // hold queued items
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[wr_ptr_q] <= page_red;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/arc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arc_back: ARC list engine
// Sequences page table lookups, unlinks and MRU inserts for one item at a
// time and presents the result for one cycle.
// ----------------------------------------------------------------------------
module arc_back import arc_pkg::*; #(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  localparam int PW = $clog2(PAGE_COUNT),
  localparam int LW = PW + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire logic [PW-1:0]      item_page_i,
  input  wire logic [CAP_W-1:0]   cap_i,
  output back_stat_t              stat_o,
  output logic                    result_valid_o,
  output logic                    was_hit_o,
  output logic [2:0]              found_in_o,
  output logic                    demoted_valid_o,
  output logic [PAGE_W-1:0]       demoted_page_o,
  output logic                    demoted_to_o,
  output logic                    dropped_valid_o,
  output logic [PAGE_W-1:0]       dropped_page_o,
  output logic [CAP_W-1:0]        target_t1_o,
  output logic [FAULT_W-1:0]      fault_count_o
);

  localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);
  localparam int PSW = ((LW > CAP_W) ? LW : CAP_W) + 1;
  localparam int TW  = ((LW + 2) > (CAP_W + 1)) ? (LW + 2) : (CAP_W + 1);

  st_e state_q, state_d;

  // page table
  logic [2:0]    tag_mem  [PAGE_COUNT];
  logic [LW-1:0] prev_mem [PAGE_COUNT];
  logic [LW-1:0] next_mem [PAGE_COUNT];
  logic [2:0]    tag_rd_q;
  logic [LW-1:0] prev_rd_q, next_rd_q;

  logic          tag_we, prev_we, next_we;
  logic [PW-1:0] tag_wa, prev_wa, next_wa, link_ra;
  logic [2:0]    tag_wd;
  logic [LW-1:0] prev_wd, next_wd;

  // list state
  logic [LW-1:0] head_q [4];
  logic [LW-1:0] tail_q [4];
  logic [LW-1:0] size_q [4];
  logic [CAP_W-1:0]   p_q;
  logic [FAULT_W-1:0] miss_q;
  logic [PW-1:0]      clr_cnt_q;

  // per-item plan
  logic [PW-1:0] cur_pg_q, op_pg_q, mpg;
  logic [1:0]    op_list_q, ref_list_q, ref_unl_list_q, drop_list_q, ulist, plist;
  tag_e          found_q, look_tag;
  logic [LW-1:0] h_q;
  logic          do_drop_q, do_repl_q, repl_b2_q, ref_unlink_q, need_div_q, ghost_b2_q;
  logic          dem_valid_q, dem_to_q, drop_valid_q;
  logic [PW-1:0] dem_page_q, drop_page_q;

  // lookup decisions
  logic [LW-1:0] t1, t2, b1, b2;
  logic [TW-1:0] t1b1, total;
  logic          m_drop, m_repl;
  logic [1:0]    m_drop_list;
  logic          g_need;
  logic [LW-1:0] div_a, div_b, div_quot;
  logic          div_start, div_done;
  logic [1:0]    src;
  logic [LW-1:0] delta;
  logic [PSW-1:0] psum;
  logic [CAP_W-1:0] p_new;
  st_e           after_repl, after_drop;
  logic          is_u1, is_p0, is_p1;

  assign t1 = size_q[LIST_T1];
  assign t2 = size_q[LIST_T2];
  assign b1 = size_q[LIST_B1];
  assign b2 = size_q[LIST_B2];
  assign t1b1  = TW'(t1) + TW'(b1);
  assign total = TW'(t1) + TW'(t2) + TW'(b1) + TW'(b2);
  assign look_tag = (tag_rd_q > TAG_B2) ? TAG_NONE : tag_e'(tag_rd_q);

  // classify a full miss into the case A / case B evictions
  always_comb begin
    m_drop      = 1'b0;
    m_repl      = 1'b0;
    m_drop_list = LIST_B1;
    if (t1b1 >= TW'(cap_i)) begin
      m_drop = 1'b1;
      if (TW'(t1) < TW'(cap_i)) begin
        m_repl = 1'b1;
      end else begin
        m_drop_list = LIST_T1;
      end
    end else if (total >= TW'(cap_i)) begin
      m_repl = 1'b1;
      if (total >= TW'({cap_i, 1'b0})) begin
        m_drop      = 1'b1;
        m_drop_list = LIST_B2;
      end
    end
  end

  // ghost hit adaptation operands
  always_comb begin
    if (look_tag == TAG_B1) begin
      g_need = !((b1 >= b2) || (b1 == '0));
      div_a  = b2;
      div_b  = b1;
    end else begin
      g_need = !((b2 >= b1) || (b2 == '0));
      div_a  = b1;
      div_b  = b2;
    end
  end

  assign div_start = (state_q == ST_LOOK) &&
                     ((look_tag == TAG_B1) || (look_tag == TAG_B2)) && g_need;

  arc_div #(.W(LW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign delta = need_div_q ? div_quot : LW'(1);
  assign psum  = PSW'(p_q) + PSW'(delta);
  always_comb begin
    if (ghost_b2_q) begin
      p_new = (PSW'(p_q) > PSW'(delta)) ? CAP_W'(PSW'(p_q) - PSW'(delta)) : '0;
    end else begin
      p_new = (psum > PSW'(cap_i)) ? cap_i : CAP_W'(psum);
    end
  end

  // pick the list that gives up a resident page
  always_comb begin
    if (((t1 != '0) && ((PSW'(t1) > PSW'(p_q)) || (repl_b2_q && (PSW'(t1) == PSW'(p_q)))))
        || (t2 == '0)) begin
      src = LIST_T1;
    end else begin
      src = LIST_T2;
    end
  end

  assign after_repl = ref_unlink_q ? ST_REF_U0 : ST_REF_P0;
  assign after_drop = do_repl_q ? ST_REPL_SEL : ST_REF_P0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_cnt_q == PW'(PAGE_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE:     if (item_valid_i) state_d = ST_LOOK;
      ST_LOOK: begin
        if ((look_tag == TAG_T1) || (look_tag == TAG_T2)) begin
          state_d = ST_REF_U0;
        end else if ((look_tag == TAG_B1) || (look_tag == TAG_B2)) begin
          state_d = ST_DIV;
        end else if (m_drop) begin
          state_d = ST_DROP_SEL;
        end else if (m_repl) begin
          state_d = ST_REPL_SEL;
        end else begin
          state_d = ST_REF_P0;
        end
      end
      ST_DIV:      if (!need_div_q || div_done) state_d = ST_REPL_SEL;
      ST_DROP_SEL: state_d = (tail_q[drop_list_q] == NIL) ? after_drop : ST_DROP_U0;
      ST_DROP_U0:  state_d = ST_DROP_U1;
      ST_DROP_U1:  state_d = after_drop;
      ST_REPL_SEL: state_d = (tail_q[src] == NIL) ? after_repl : ST_REPL_U0;
      ST_REPL_U0:  state_d = ST_REPL_U1;
      ST_REPL_U1:  state_d = ST_REPL_P0;
      ST_REPL_P0:  state_d = ST_REPL_P1;
      ST_REPL_P1:  state_d = after_repl;
      ST_REF_U0:   state_d = ST_REF_U1;
      ST_REF_U1:   state_d = ST_REF_P0;
      ST_REF_P0:   state_d = ST_REF_P1;
      ST_REF_P1:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // micro-operation decode
  always_comb begin
    is_u1 = 1'b0;
    is_p0 = 1'b0;
    is_p1 = 1'b0;
    mpg   = op_pg_q;
    ulist = op_list_q;
    plist = {1'b1, op_list_q[0]};
    case (state_q)
      ST_DROP_U1, ST_REPL_U1: is_u1 = 1'b1;
      ST_REPL_P0:             is_p0 = 1'b1;
      ST_REPL_P1:             is_p1 = 1'b1;
      ST_REF_U0: begin
        mpg = cur_pg_q;
      end
      ST_REF_U1: begin
        is_u1 = 1'b1;
        mpg   = cur_pg_q;
        ulist = ref_unl_list_q;
      end
      ST_REF_P0: begin
        is_p0 = 1'b1;
        mpg   = cur_pg_q;
        plist = ref_list_q;
      end
      ST_REF_P1: begin
        is_p1 = 1'b1;
        mpg   = cur_pg_q;
        plist = ref_list_q;
      end
      default: begin
        is_u1 = 1'b0;
      end
    endcase
  end

  // page table write controls
  always_comb begin
    tag_we  = 1'b0;
    tag_wa  = mpg;
    tag_wd  = TAG_NONE;
    prev_we = 1'b0;
    prev_wa = mpg;
    prev_wd = NIL;
    next_we = 1'b0;
    next_wa = mpg;
    next_wd = head_q[plist];
    link_ra = mpg;
    if (state_q == ST_CLEAR) begin
      tag_we = 1'b1;
      tag_wa = clr_cnt_q;
    end else if (is_u1) begin
      tag_we  = 1'b1;
      next_we = (prev_rd_q != NIL);
      next_wa = prev_rd_q[PW-1:0];
      next_wd = next_rd_q;
      prev_we = (next_rd_q != NIL);
      prev_wa = next_rd_q[PW-1:0];
      prev_wd = prev_rd_q;
    end else if (is_p0) begin
      tag_we  = 1'b1;
      tag_wd  = {1'b0, plist} + 3'd1;
      prev_we = 1'b1;
      next_we = 1'b1;
    end else if (is_p1) begin
      prev_we = (h_q != NIL);
      prev_wa = h_q[PW-1:0];
      prev_wd = {1'b0, mpg};
    end
  end

  // page table memories
  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd_q <= tag_mem[item_page_i];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_q <= prev_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_q <= next_mem[link_ra];
  end

  // control state: sequencer, list ends, sizes, target and fault count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      p_q       <= '0;
      miss_q    <= '0;
      for (int i = 0; i < 4; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
        size_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if ((state_q == ST_LOOK) && (look_tag != TAG_T1) && (look_tag != TAG_T2) &&
          (miss_q != '1)) begin
        miss_q <= miss_q + 1'b1;
      end
      if ((state_q == ST_DIV) && (state_d == ST_REPL_SEL)) begin
        p_q <= p_new;
      end
      if (is_u1) begin
        if (prev_rd_q == NIL) head_q[ulist] <= next_rd_q;
        if (next_rd_q == NIL) tail_q[ulist] <= prev_rd_q;
        if (size_q[ulist] != '0) size_q[ulist] <= size_q[ulist] - 1'b1;
      end
      if (is_p1) begin
        if (h_q == NIL) tail_q[plist] <= {1'b0, mpg};
        head_q[plist] <= {1'b0, mpg};
        size_q[plist] <= size_q[plist] + 1'b1;
      end
    end
  end

  // per-item plan and result fields
  always_ff @(posedge clk_i) begin
    if (is_p0) h_q <= head_q[plist];
    case (state_q)
      ST_IDLE: begin
        cur_pg_q <= item_page_i;
      end
      ST_LOOK: begin
        found_q        <= look_tag;
        ref_unlink_q   <= (look_tag != TAG_NONE);
        ref_unl_list_q <= 2'(look_tag) - 2'd1;
        ref_list_q     <= (look_tag == TAG_NONE) ? LIST_T1 : LIST_T2;
        repl_b2_q      <= (look_tag == TAG_B2);
        ghost_b2_q     <= (look_tag == TAG_B2);
        need_div_q     <= g_need;
        do_drop_q      <= m_drop;
        drop_list_q    <= m_drop_list;
        do_repl_q      <= m_repl;
        dem_valid_q    <= 1'b0;
        dem_page_q     <= '0;
        dem_to_q       <= 1'b0;
        drop_valid_q   <= 1'b0;
        drop_page_q    <= '0;
      end
      ST_DROP_SEL: begin
        op_pg_q   <= tail_q[drop_list_q][PW-1:0];
        op_list_q <= drop_list_q;
        if (tail_q[drop_list_q] != NIL) begin
          drop_valid_q <= 1'b1;
          drop_page_q  <= tail_q[drop_list_q][PW-1:0];
        end
      end
      ST_REPL_SEL: begin
        op_pg_q   <= tail_q[src][PW-1:0];
        op_list_q <= src;
        if (tail_q[src] != NIL) begin
          dem_valid_q <= 1'b1;
          dem_page_q  <= tail_q[src][PW-1:0];
          dem_to_q    <= src[0];
        end
      end
      default: begin
        op_pg_q <= op_pg_q;
      end
    endcase
  end

  // result comes out in the cycle after the final insert
  logic res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= 1'b0;
    end else begin
      res_q <= (state_q == ST_REF_P1);
    end
  end

  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.pop      = (state_q == ST_IDLE) && item_valid_i;

  assign result_valid_o  = res_q;
  assign was_hit_o       = (found_q == TAG_T1) || (found_q == TAG_T2);
  assign found_in_o      = found_q;
  assign demoted_valid_o = dem_valid_q;
  assign demoted_page_o  = PAGE_W'(dem_page_q);
  assign demoted_to_o    = dem_to_q;
  assign dropped_valid_o = drop_valid_q;
  assign dropped_page_o  = PAGE_W'(drop_page_q);
  assign target_t1_o     = p_q;
  assign fault_count_o   = miss_q;

`ifndef ASSERT_OFF
  a_res_after_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |-> $past(state_q) == ST_REF_P1)
    else $error("result strobe without a finished insert");

  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.clearing |-> !stat_o.pop)
    else $error("item taken during clearing pass");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait state");

  a_sizes_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> total <= TW'(PAGE_COUNT))
    else $error("list sizes exceed page count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/arc_cache_replacement_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arc_cache_replacement_core: adaptive replacement cache policy engine
// Takes one page reference per command and reports hit, origin list,
// demotion, drop, target size and fault count.
// ----------------------------------------------------------------------------
// After reset the page table is cleared with busy held high. Once the back
// end is free, an item's result follows a page table lookup, any drop,
// demotion or unlink, and the MRU insert; a ghost hit that adapts its target
// by a list size ratio also waits on the bit-serial divider.
// A two-entry queue takes new items while one is at work. Each result is
// shown for exactly one cycle on result_valid_o and cannot be held off.
module arc_cache_replacement_core import arc_pkg::*; #(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [PAGE_W-1:0]  page_number_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CAP_W-1:0]   cfg_wdata_i,
  output logic                    result_valid_o,
  output logic                    was_hit_o,
  output logic [2:0]              found_in_o,
  output logic                    demoted_valid_o,
  output logic [PAGE_W-1:0]       demoted_page_o,
  output logic                    demoted_to_o,
  output logic                    dropped_valid_o,
  output logic [PAGE_W-1:0]       dropped_page_o,
  output logic [CAP_W-1:0]        target_t1_o,
  output logic [FAULT_W-1:0]      fault_count_o
);

  localparam int PW = $clog2(PAGE_COUNT);

  logic [CAP_W-1:0] cap_q;
  back_stat_t       stat;
  logic             item_valid;
  logic [PW-1:0]    item_page;

  // hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  arc_front #(.PAGE_COUNT(PAGE_COUNT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .page_number_i (page_number_i),
    .stat_i        (stat),
    .item_valid_o  (item_valid),
    .item_page_o   (item_page)
  );

  arc_back #(.PAGE_COUNT(PAGE_COUNT)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_page_i     (item_page),
    .cap_i           (cap_q),
    .stat_o          (stat),
    .result_valid_o  (result_valid_o),
    .was_hit_o       (was_hit_o),
    .found_in_o      (found_in_o),
    .demoted_valid_o (demoted_valid_o),
    .demoted_page_o  (demoted_page_o),
    .demoted_to_o    (demoted_to_o),
    .dropped_valid_o (dropped_valid_o),
    .dropped_page_o  (dropped_page_o),
    .target_t1_o     (target_t1_o),
    .fault_count_o   (fault_count_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb_arc_cache_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arc_cache_replacement_core: self-checking bench for the ARC policy core
// Drives page references through the start/busy handshake, mirrors the ARC
// lists, target size and fault count in a local predictor, and compares every
// result field by field. Capacity is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_arc_cache_replacement_core;
  import arc_pkg::*;

  localparam int NPAGE = PAGE_COUNT_DEF;
  localparam int NIL = NPAGE;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic              hit;
    logic [2:0]        found;
    logic              dem_v;
    logic [PAGE_W-1:0] dem_pg;
    logic              dem_to;
    logic              drop_v;
    logic [PAGE_W-1:0] drop_pg;
    logic [CAP_W-1:0]  tgt;
    logic [FAULT_W-1:0] faults;
  } arc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PAGE_W-1:0] page_number_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;
  logic result_valid_o, was_hit_o, demoted_valid_o, demoted_to_o, dropped_valid_o;
  logic [2:0] found_in_o;
  logic [PAGE_W-1:0] demoted_page_o, dropped_page_o;
  logic [CAP_W-1:0] target_t1_o;
  logic [FAULT_W-1:0] fault_count_o;

  arc_cache_replacement_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .page_number_i(page_number_i), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .result_valid_o(result_valid_o), .was_hit_o(was_hit_o), .found_in_o(found_in_o),
    .demoted_valid_o(demoted_valid_o), .demoted_page_o(demoted_page_o),
    .demoted_to_o(demoted_to_o), .dropped_valid_o(dropped_valid_o),
    .dropped_page_o(dropped_page_o), .target_t1_o(target_t1_o),
    .fault_count_o(fault_count_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ARC mirror state
  tag_e        page_tag [NPAGE];
  int unsigned page_prv [NPAGE];
  int unsigned page_nxt [NPAGE];
  int unsigned head [4];
  int unsigned tail [4];
  int unsigned lsize [4];
  int unsigned p_target;
  logic [FAULT_W-1:0] miss_cnt;
  int unsigned capacity;
  arc_result_t cur;

  logic [PAGE_W-1:0] pending_pages [$];
  arc_result_t       expected_results [$];
  int unsigned idle_pct;
  int unsigned mismatches;
  int unsigned cycles;
  bit          item_taken;

  function automatic void arc_clear();
    for (int i = 0; i < NPAGE; i++) begin
      page_tag[i] = TAG_NONE;
      page_prv[i] = 0;
      page_nxt[i] = 0;
    end
    for (int l = 0; l < 4; l++) begin
      head[l] = NIL;
      tail[l] = NIL;
      lsize[l] = 0;
    end
    p_target = 0;
    miss_cnt = '0;
    capacity = CAP_RESET;
  endfunction

  function automatic void list_unlink(int unsigned pg);
    int unsigned l, pv, nx;
    if (page_tag[pg] == TAG_NONE) return;
    l = int'(page_tag[pg]) - 1;
    pv = page_prv[pg];
    nx = page_nxt[pg];
    if (pv >= NIL) head[l] = nx;
    else page_nxt[pv] = nx;
    if (nx >= NIL) tail[l] = pv;
    else page_prv[nx] = pv;
    if (lsize[l] > 0) lsize[l]--;
    page_tag[pg] = TAG_NONE;
  endfunction

  function automatic void list_push_mru(int unsigned pg, int unsigned l);
    int unsigned h;
    h = head[l];
    page_prv[pg] = NIL;
    page_nxt[pg] = h;
    if (h < NIL) page_prv[h] = pg;
    else tail[l] = pg;
    head[l] = pg;
    lsize[l]++;
    page_tag[pg] = tag_e'(l + 1);
  endfunction

  function automatic int unsigned list_pop_lru(int unsigned l);
    int unsigned pg;
    pg = tail[l];
    if (pg < NIL) list_unlink(pg);
    return pg;
  endfunction

  function automatic void drop_from(int unsigned l);
    int unsigned pg;
    pg = list_pop_lru(l);
    if (pg < NIL) begin
      cur.drop_v = 1'b1;
      cur.drop_pg = pg[PAGE_W-1:0];
    end
  endfunction

  // demote one resident page into its ghost list
  function automatic void demote_one(bit ref_in_b2);
    int unsigned t1, src, pg;
    t1 = lsize[LIST_T1];
    if ((t1 > 0 && (t1 > p_target || (ref_in_b2 && t1 == p_target))) ||
        lsize[LIST_T2] == 0)
      src = LIST_T1;
    else
      src = LIST_T2;
    pg = list_pop_lru(src);
    if (pg >= NIL) return;
    list_push_mru(pg, src + 2);
    cur.dem_v = 1'b1;
    cur.dem_pg = pg[PAGE_W-1:0];
    cur.dem_to = src[0];
  endfunction

  function automatic arc_result_t arc_reference(int unsigned pg);
    tag_e tg;
    int unsigned b1, b2, t1, total, delta;
    tg = page_tag[pg];
    b1 = lsize[LIST_B1];
    b2 = lsize[LIST_B2];
    t1 = lsize[LIST_T1];
    cur = '0;
    cur.found = tg;
    if (tg != TAG_T1 && tg != TAG_T2 && miss_cnt != '1) miss_cnt++;
    case (tg)
      TAG_T1, TAG_T2: begin
        cur.hit = 1'b1;
        list_unlink(pg);
        list_push_mru(pg, LIST_T2);
      end
      TAG_B1: begin
        delta = (b1 >= b2 || b1 == 0) ? 1 : b2 / b1;
        p_target = (p_target + delta > capacity) ? capacity : p_target + delta;
        demote_one(1'b0);
        list_unlink(pg);
        list_push_mru(pg, LIST_T2);
      end
      TAG_B2: begin
        delta = (b2 >= b1 || b2 == 0) ? 1 : b1 / b2;
        p_target = (p_target > delta) ? p_target - delta : 0;
        demote_one(1'b1);
        list_unlink(pg);
        list_push_mru(pg, LIST_T2);
      end
      default: begin
        total = t1 + lsize[LIST_T2] + b1 + b2;
        if (t1 + b1 >= capacity) begin
          if (t1 < capacity) begin
            drop_from(LIST_B1);
            demote_one(1'b0);
          end else begin
            drop_from(LIST_T1);
          end
        end else if (total >= capacity) begin
          if (total >= 2 * capacity) drop_from(LIST_B2);
          demote_one(1'b0);
        end
        list_push_mru(pg, LIST_T1);
      end
    endcase
    cur.tgt = p_target[CAP_W-1:0];
    cur.faults = miss_cnt;
    return cur;
  endfunction

  // sample handshakes, check results, track config writes
  always @(posedge clk_i) begin
    arc_result_t want, got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      if (rst_ni && result_valid_o) begin
        got = '{was_hit_o, found_in_o, demoted_valid_o, demoted_page_o, demoted_to_o,
                dropped_valid_o, dropped_page_o, target_t1_o, fault_count_o};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: hit %b/%b found %0d/%0d dem %b %0d %b / %b %0d %b",
                       want.hit, got.hit, want.found, got.found,
                       want.dem_v, want.dem_pg, want.dem_to, got.dem_v, got.dem_pg,
                       got.dem_to,
                       " drop %b %0d / %b %0d p %0d/%0d faults %0d/%0d",
                       want.drop_v, want.drop_pg, got.drop_v, got.drop_pg,
                       want.tgt, got.tgt, want.faults, got.faults);
          end
        end
      end
      if (rst_ni && start && !busy) begin
        expected_results.push_back(arc_reference(page_number_i));
        item_taken = 1'b1;
      end
      if (rst_ni && cfg_we_i) capacity = cfg_wdata_i;
    end
  end

  // feed items from the pending queue, idling at random
  always @(negedge clk_i) begin
    if (!start || item_taken) begin
      item_taken = 1'b0;
      if (pending_pages.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        page_number_i <= pending_pages.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (pending_pages.size() != 0 || start || expected_results.size() != 0 || busy)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_capacity(int unsigned c);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c[CAP_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned caps [8] = '{1, 8, 512, 0, 3, 64, 1023, 5};
    int unsigned pool, done_items;
    int unsigned directed [20] = '{0, 1023, 0, 0, 5, 6, 1023, 7, 0, 5, 8, 6, 9, 512,
                                   7, 511, 8, 1, 9, 1023};
    arc_clear();
    mismatches = 0;
    cycles = 0;
    idle_pct = 27;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    // wait out the table clearing pass
    @(negedge clk_i);
    while (busy) @(negedge clk_i);

    // directed: tiny cache so T1/T2 hits and B1 drops and demotions come early
    set_capacity(2);
    foreach (directed[i]) pending_pages.push_back(directed[i][PAGE_W-1:0]);
    wait_drained();

    done_items = 0;
    foreach (caps[k]) begin
      set_capacity(caps[k]);
      pool = (caps[k] & 10'h3FF) * 3 + 3;
      if (pool > NPAGE) pool = NPAGE;
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(9) == 0)
          pending_pages.push_back(PAGE_W'($urandom_range(NPAGE - 1)));
        else
          pending_pages.push_back(PAGE_W'($urandom_range(pool - 1)));
      end
      // switch idling pattern as the run progresses
      while (pending_pages.size() != 0) begin
        @(negedge clk_i);
        if (done_items + 100 - pending_pages.size() > 560) idle_pct = 0;
        else if (done_items + 100 - pending_pages.size() > 280) idle_pct = 67;
      end
      done_items += 100;
      wait_drained();
    end

    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/arc_pkg.sv
rtl/core/arc_div.sv
rtl/core/arc_front.sv
rtl/core/arc_back.sv
rtl/core/arc_cache_replacement_core.sv
sim/tb_arc_cache_replacement_core.sv
